@@ rtl/ltel_pkg.sv @@
// shared constants, opcodes and types of the line table encoder and lookup
package ltel_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int OFFSET_BITS_DEF = 20;

  localparam int OPCODE_W = 2;
  localparam int COUNT_W  = 16;
  localparam int QOFS_W   = 20;
  localparam int LINE_W   = 13;
  localparam int COL_W    = 21;

  localparam logic [7:0] NEW_LINE_MARK = 8'h80;
  localparam logic [6:0] LEN_MASK      = 7'h7f;

  localparam logic [OPCODE_W-1:0] OP_NEWLINE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP     = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
    logic              found;
    logic              table_full;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

@@ rtl/ltel_if.sv @@
// request and result channel interfaces
interface ltel_in_if;
  logic                           valid;
  logic                           ready;
  logic [ltel_pkg::OPCODE_W-1:0]  opcode;
  logic [ltel_pkg::COUNT_W-1:0]   byte_count;
  logic [ltel_pkg::QOFS_W-1:0]    query_offset;

  modport source(output valid, opcode, byte_count, query_offset, input ready);
  modport sink(input valid, opcode, byte_count, query_offset, output ready);
endinterface

interface ltel_out_if;
  logic                          valid;
  logic                          ready;
  logic [ltel_pkg::LINE_W-1:0]   line_number;
  logic [ltel_pkg::COL_W-1:0]    column;
  logic                          found;
  logic                          table_full;

  modport source(output valid, line_number, column, found, table_full, input ready);
  modport sink(input valid, line_number, column, found, table_full, output ready);
endinterface

@@ rtl/ltel_store.sv @@
// line table memory, one write port and one registered read port
module ltel_store #(
  parameter int STORE_DEPTH = ltel_pkg::STORE_DEPTH_DEF
) (
  input  logic                               clk,
  input  ltel_pkg::mem_ctl_t                 mem_ctl,
  input  logic [$clog2(STORE_DEPTH)-1:0]     waddr,
  input  logic [7:0]                         wdata,
  input  logic [$clog2(STORE_DEPTH)-1:0]     raddr,
  output logic [7:0]                         rdata
);

  logic [7:0] line_mem_r [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      line_mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= line_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ltel_ctrl.sv @@
// request sequencer: appends, advance continuation and table walk
module ltel_ctrl #(
  parameter int STORE_DEPTH = ltel_pkg::STORE_DEPTH_DEF,
  parameter int OFFSET_BITS = ltel_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ltel_in_if.sink                         in_ch,
  output ltel_pkg::mem_ctl_t              mem_ctl,
  output logic [$clog2(STORE_DEPTH)-1:0]  mem_waddr,
  output logic [7:0]                      mem_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0]  mem_raddr,
  input  logic [7:0]                      mem_rdata,
  output logic                            res_valid,
  output ltel_pkg::res_t                  res,
  input  logic                            res_ready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int LW = CW;
  localparam int PW = $clog2(STORE_DEPTH * 128 + 1);
  localparam int TW = (OFFSET_BITS < ltel_pkg::QOFS_W) ? OFFSET_BITS : ltel_pkg::QOFS_W;
  localparam int XW = ((PW > TW) ? PW : TW) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADV  = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [7:0]     last_r, last_nxt;
  logic [15:0]    rem_r, rem_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  start_r, start_nxt;
  logic [LW-1:0]  line_r, line_nxt;
  logic [TW-1:0]  target_r, target_nxt;
  ltel_pkg::res_t res_r, res_nxt;

  logic           accept;
  logic           empty;
  logic           has_room;
  logic [CW-1:0]  last_addr;
  logic [6:0]     cur_len;
  logic [7:0]     base;
  logic [16:0]    sum17;
  logic [16:0]    over17;
  logic [6:0]     chunk;
  logic           mark;
  logic [PW-1:0]  q_start;
  logic [PW-1:0]  q_pos;
  logic [LW-1:0]  q_line;
  logic           q_hit;
  logic           q_last;
  logic [XW-1:0]  col_full;
  logic [XW+ltel_pkg::COL_W-1:0]  col_ext;
  logic [LW+ltel_pkg::LINE_W-1:0] line_ext;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign empty     = (count_r == '0);
  assign has_room  = (count_r < CW'(STORE_DEPTH));
  assign last_addr = count_r - CW'(1);

  // advance start: fill the last entry, implicit first line on empty table
  assign cur_len = empty ? 7'd0 : last_r[6:0];
  assign base    = empty ? ltel_pkg::NEW_LINE_MARK : last_r;
  assign sum17   = 17'(cur_len) + 17'(in_ch.byte_count);
  assign over17  = sum17 - 17'(ltel_pkg::LEN_MASK);
  assign chunk   = (rem_r > 16'(ltel_pkg::LEN_MASK)) ? ltel_pkg::LEN_MASK : rem_r[6:0];

  // walk step on the entry that just came out of the memory
  assign mark     = mem_rdata[7];
  assign q_start  = mark ? pos_r : start_r;
  assign q_line   = line_r + LW'(mark);
  assign q_pos    = pos_r + PW'(mark) + PW'(mem_rdata[6:0]);
  assign q_hit    = XW'(q_pos) >= XW'(target_r);
  assign q_last   = (CW'(idx_r) + CW'(1)) == count_r;
  assign col_full = XW'(target_r) + XW'(1) - XW'(q_start);
  assign col_ext  = {{ltel_pkg::COL_W{1'b0}}, col_full};
  assign line_ext = {{ltel_pkg::LINE_W{1'b0}}, q_line};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    line_nxt   = line_r;
    target_nxt = target_r;
    res_nxt    = res_r;
    mem_ctl    = '0;
    mem_waddr  = count_r[AW-1:0];
    mem_wdata  = ltel_pkg::NEW_LINE_MARK;
    mem_raddr  = idx_r + AW'(1);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_ch.opcode)
            ltel_pkg::OP_NEWLINE: begin
              if (has_room) begin
                mem_ctl.wr_en = 1'b1;
                count_nxt     = count_r + CW'(1);
                last_nxt      = ltel_pkg::NEW_LINE_MARK;
              end else begin
                res_nxt.table_full = 1'b1;
              end
            end
            ltel_pkg::OP_ADVANCE: begin
              mem_ctl.wr_en = 1'b1;
              mem_waddr     = empty ? '0 : last_addr[AW-1:0];
              count_nxt     = empty ? CW'(1) : count_r;
              if (sum17 <= 17'(ltel_pkg::LEN_MASK)) begin
                mem_wdata = {base[7], sum17[6:0]};
              end else begin
                mem_wdata = base | {1'b0, ltel_pkg::LEN_MASK};
                rem_nxt   = over17[15:0];
                state_nxt = S_ADV;
              end
              last_nxt = mem_wdata;
            end
            ltel_pkg::OP_QUERY: begin
              target_nxt = in_ch.query_offset[TW-1:0];
              idx_nxt    = '0;
              pos_nxt    = '0;
              start_nxt  = '0;
              line_nxt   = '0;
              if (!empty) begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = '0;
                state_nxt     = S_QRY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADV: begin
        if (rem_r == '0) begin
          state_nxt = S_DONE;
        end else if (!has_room) begin
          res_nxt.table_full = 1'b1;
          state_nxt          = S_DONE;
        end else begin
          mem_ctl.wr_en = 1'b1;
          mem_wdata     = {1'b0, chunk};
          last_nxt      = {1'b0, chunk};
          count_nxt     = count_r + CW'(1);
          rem_nxt       = rem_r - 16'(chunk);
        end
      end
      S_QRY: begin
        start_nxt = q_start;
        line_nxt  = q_line;
        pos_nxt   = q_pos;
        if (q_hit) begin
          res_nxt.found       = 1'b1;
          res_nxt.line_number = line_ext[ltel_pkg::LINE_W-1:0];
          res_nxt.column      = col_ext[ltel_pkg::COL_W-1:0];
          state_nxt           = S_DONE;
        end else if (q_last) begin
          state_nxt = S_DONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          idx_nxt       = idx_r + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    rem_r    <= rem_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    start_r  <= start_nxt;
    line_r   <= line_nxt;
    target_r <= target_nxt;
    res_r    <= res_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

@@ rtl/line_table_encode_lookup_top.sv @@
// top level of the line table encoder and lookup
// The block keeps a byte table that run-length codes source line lengths in a
// single on-chip memory of STORE_DEPTH bytes: bit 7 of an entry opens a new
// line, bits 6:0 count up to 127 characters. Each request carries an opcode:
// newline appends 0x80; advance adds byte_count to the last entry and spills
// into continuation entries of at most 127 (an empty table first gets an
// implicit line); query walks the table from the start and returns the line
// and column of query_offset, or found = 0. A newline that does not fit is
// dropped, and an advance that runs out of room keeps the entries it wrote;
// either way table_full is raised in that request's result. Exactly one
// result comes back per request, in order. A newline or advance makes its
// first write when the request is accepted; an advance that spills then
// writes its continuation entries in turn (at most 517 entries for byte_count
// 65535), since the memory takes one write a cycle. A query reads one table
// entry a cycle through the memory's registered read port, up to the entry
// count, and stops at the first hit. A new request is taken as soon as the
// previous result has moved into the output register, even if the sink has
// not taken it yet. The entry count is cleared by reset; the memory itself
// needs no clearing pass, as only entries below the count are ever read.
module line_table_encode_lookup_top #(
  parameter int STORE_DEPTH = ltel_pkg::STORE_DEPTH_DEF,
  parameter int OFFSET_BITS = ltel_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ltel_in_if.sink       in_ch,
  ltel_out_if.source    out_ch
);

  localparam int AW = $clog2(STORE_DEPTH);

  // memory port between sequencer and store
  ltel_pkg::mem_ctl_t  mem_ctl;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [7:0]          mem_rdata;

  // finished result from the sequencer
  logic                res_valid;
  logic                res_ready;
  ltel_pkg::res_t      res;

  // output register, parts the sequencer from the sink
  logic                out_valid_r;
  ltel_pkg::res_t      out_res_r;

  ltel_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

  ltel_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // the register takes a new result when empty or draining this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_number = out_res_r.line_number;
  assign out_ch.column      = out_res_r.column;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.table_full  = out_res_r.table_full;

  // a hit always lies at or after its line start, so the column is nonzero
  a_found_col : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> out_ch.column != '0)
    else $error("found result with zero column");

  // only appends can overflow, only queries can hit
  a_full_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.found && out_ch.table_full))
    else $error("result both found and full");

  // the sequencer never takes a request while it still holds a result
  a_idle_nores : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !res_valid)
    else $error("request taken while result pending");

  // a held result stays until the output register takes it
  a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before hand-off");

endmodule
